/* rtl/wsd_pkg.sv */
// Shared types and codes for the WebSocket frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RSV      = 3'd1;
  localparam logic [2:0] ST_MASKED   = 3'd2;
  localparam logic [2:0] ST_LONG_LEN = 3'd3;
  localparam logic [2:0] ST_CLOSE    = 3'd4;
  localparam logic [2:0] ST_PONG_BAD = 3'd5;

  localparam logic [7:0] HDR_RSV_MASK = 8'h70;
  localparam logic [7:0] HDR_OP_MASK  = 8'h0F;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  typedef struct packed {
    logic [2:0] status;
    logic       final_fragment;
    logic [3:0] frame_opcode;
    logic       payload_valid;
    logic       frame_end;
    logic [7:0] payload_byte;
  } wsd_res_t;

endpackage

`default_nettype wire

/* rtl/websocket_frame_deframer_top.sv */
// Top level of the WebSocket frame deframer: header parse, payload tagging, pong check.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   in_*  : one received byte per word, with resync and the expected ping
//           count riding along. A word with resync set clears the parser and
//           any error halt and gives no result.
//   out_* : one word per payload byte, tagged with opcode, FIN and status;
//           tlast marks the frame end. An empty frame gives one word with
//           payload_valid low and tlast high. Header errors give one word
//           with the error status and tlast low; the block then drops all
//           words until resync.
//   A result is registered into the output register, or into the skid
//   register while the output waits. Input words are taken at one word per
//   cycle while in_tready is high.
//   Stall: a two-entry output buffer (output register plus skid register)
//   lets in_tready stay high for one more result while the output waits; it
//   drops only when both entries are full.
//   Reset (rst_n low, synchronous): parser to first header byte, halt
//   cleared, output buffer emptied.
module websocket_frame_deframer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] in_byte, [14:8] expected_ping, [15] zero
  input  wire logic        in_tuser,   // [0] resync
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] payload_byte
  output logic             out_tlast,  // frame_end
  output logic [8:0]       out_tuser   // [0] payload_valid, [4:1] frame_opcode,
                                       // [5] final_fragment, [8:6] status
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXT_HI  = 3'd2;
  localparam logic [2:0] PH_EXT_LO  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        fin_r, fin_nxt;
  logic [7:0]  ext_hi_r, ext_hi_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [13:0] pong_r, pong_nxt;
  logic        digits_ok_r, digits_ok_nxt;
  logic        halted_r, halted_nxt;

  logic        out_valid_r, skid_valid_r;
  wsd_res_t    out_res_r, skid_res_r;

  logic        in_fire;
  logic        res_emit;
  wsd_res_t    res;
  logic [7:0]  in_byte;
  logic [6:0]  exp_ping;
  logic [6:0]  len_code;
  logic        start_len;
  logic [15:0] start_val;
  logic        end_frame;
  logic [2:0]  end_status;
  logic [15:0] dec_left;
  logic [13:0] pong_mac;

  assign in_byte   = in_tdata[7:0];
  assign exp_ping  = in_tdata[14:8];
  assign len_code  = in_byte[6:0];
  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign dec_left  = bytes_left_r - 16'd1;
  // pong*10 + digit, kept to 14 bits
  assign pong_mac  = (pong_r << 3) + (pong_r << 1) + 14'(in_byte - ASCII_ZERO);

  always_comb begin
    phase_nxt      = phase_r;
    opcode_nxt     = opcode_r;
    fin_nxt        = fin_r;
    ext_hi_nxt     = ext_hi_r;
    bytes_left_nxt = bytes_left_r;
    pong_nxt       = pong_r;
    digits_ok_nxt  = digits_ok_r;
    halted_nxt     = halted_r;
    res_emit       = 1'b0;
    res            = '0;
    start_len      = 1'b0;
    start_val      = '0;
    end_frame      = 1'b0;
    end_status     = ST_OK;

    unique case (phase_r)
      PH_HDR1: begin
        if (len_code == LEN_EXT16) begin
          start_val = '0;
        end else begin
          start_val = {9'd0, len_code};
        end
      end
      PH_EXT_LO: start_val = {ext_hi_r, in_byte};
      default:   start_val = '0;
    endcase

    if (in_fire) begin
      if (in_tuser) begin
        phase_nxt      = PH_HDR0;
        opcode_nxt     = '0;
        fin_nxt        = 1'b0;
        ext_hi_nxt     = '0;
        bytes_left_nxt = '0;
        pong_nxt       = '0;
        digits_ok_nxt  = 1'b1;
        halted_nxt     = 1'b0;
      end else if (!halted_r) begin
        unique case (phase_r)
          PH_HDR0: begin
            fin_nxt    = in_byte[7];
            opcode_nxt = 4'(in_byte & HDR_OP_MASK);
            if ((in_byte & HDR_RSV_MASK) != 8'd0) begin
              halted_nxt = 1'b1;
              res_emit   = 1'b1;
              res.status = ST_RSV;
            end else begin
              phase_nxt = PH_HDR1;
            end
          end
          PH_HDR1: begin
            priority if (in_byte[7]) begin
              halted_nxt = 1'b1;
              phase_nxt  = PH_HDR0;
              res_emit   = 1'b1;
              res.status = ST_MASKED;
            end else if (len_code == LEN_EXT64) begin
              halted_nxt = 1'b1;
              phase_nxt  = PH_HDR0;
              res_emit   = 1'b1;
              res.status = ST_LONG_LEN;
            end else if (len_code == LEN_EXT16) begin
              phase_nxt = PH_EXT_HI;
            end else begin
              start_len = 1'b1;
            end
          end
          PH_EXT_HI: begin
            ext_hi_nxt = in_byte;
            phase_nxt  = PH_EXT_LO;
          end
          PH_EXT_LO: start_len = 1'b1;
          PH_PAYLOAD: begin
            if (digits_ok_r && in_byte >= ASCII_ZERO && in_byte <= ASCII_NINE) begin
              pong_nxt = pong_mac;
            end else begin
              digits_ok_nxt = 1'b0;
            end
            bytes_left_nxt    = dec_left;
            end_frame         = (dec_left == 16'd0);
            res_emit          = 1'b1;
            res.payload_byte  = in_byte;
            res.payload_valid = 1'b1;
          end
          default: phase_nxt = PH_HDR0;
        endcase

        if (start_len) begin
          bytes_left_nxt = start_val;
          digits_ok_nxt  = (start_val == 16'd4);
          pong_nxt       = '0;
          if (start_val == 16'd0) begin
            end_frame         = 1'b1;
            res_emit          = 1'b1;
            res.payload_byte  = '0;
            res.payload_valid = 1'b0;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end

        if (end_frame) begin
          // status for a frame that ends now, using the opcode captured for it
          priority if (opcode_r == OP_CLOSE) begin
            end_status = ST_CLOSE;
          end else if (opcode_r == OP_PONG && digits_ok_nxt &&
                       pong_nxt != {7'd0, exp_ping}) begin
            end_status = ST_PONG_BAD;
          end else begin
            end_status = ST_OK;
          end
          phase_nxt     = PH_HDR0;
          res.frame_end = 1'b1;
          res.status    = end_status;
          if (end_status != ST_OK) begin
            halted_nxt = 1'b1;
          end
        end

        res.frame_opcode   = opcode_nxt;
        res.final_fragment = fin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR0;
      opcode_r     <= '0;
      fin_r        <= 1'b0;
      ext_hi_r     <= '0;
      bytes_left_r <= '0;
      pong_r       <= '0;
      digits_ok_r  <= 1'b1;
      halted_r     <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      opcode_r     <= opcode_nxt;
      fin_r        <= fin_nxt;
      ext_hi_r     <= ext_hi_nxt;
      bytes_left_r <= bytes_left_nxt;
      pong_r       <= pong_nxt;
      digits_ok_r  <= digits_ok_nxt;
      halted_r     <= halted_nxt;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (res_emit) begin
        if (!out_valid_r || out_tready) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_valid_r && out_tready) begin
        out_valid_r  <= skid_valid_r;
        skid_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_emit) begin
      if (!out_valid_r || out_tready) begin
        out_res_r <= res;
      end else begin
        skid_res_r <= res;
      end
    end else if (out_valid_r && out_tready && skid_valid_r) begin
      out_res_r <= skid_res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.payload_byte;
  assign out_tlast  = out_res_r.frame_end;
  assign out_tuser  = {out_res_r.status, out_res_r.final_fragment,
                       out_res_r.frame_opcode, out_res_r.payload_valid};

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && in_fire && !in_tuser) |-> !res_emit)
    else $error("result produced while halted");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (bytes_left_r != 16'd0))
    else $error("payload phase with zero bytes left");

  a_empty_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (res_emit && !res.payload_valid && res.status == ST_OK) |-> res.frame_end)
    else $error("empty ok result without frame end");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (res_emit && res.status != ST_OK) |=> halted_r)
    else $error("error status without halt");
`endif

endmodule

`default_nettype wire

/* tb/sv/websocket_frame_deframer_top_tb.sv */
// Self-checking testbench for the WebSocket frame deframer: parsing, errors, pong check, stalls.
`timescale 1ns / 1ps

module websocket_frame_deframer_top_tb;
  import wsd_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  localparam logic [3:0] OP_CONT      = 4'h0;
  localparam logic [3:0] OP_TEXT      = 4'h1;
  localparam logic [3:0] OP_BINARY    = 4'h2;
  localparam logic [3:0] OP_RSVD_DATA = 4'h3;
  localparam logic [3:0] OP_PING      = 4'h9;
  localparam logic [3:0] OP_RSVD_CTRL = 4'hB;

  typedef enum logic [2:0] {
    AWAIT_HDR0, AWAIT_HDR1, AWAIT_EXT_HI, AWAIT_EXT_LO, IN_PAYLOAD
  } hdr_phase_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [7:0] in_byte, [14:8] expected_ping, [15] zero
  logic        in_tuser = 1'b0; // [0] resync
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] payload_byte
  logic        out_tlast;       // frame_end
  logic [8:0]  out_tuser;       // [0] payload_valid, [4:1] frame_opcode,
                                // [5] final_fragment, [8:6] status

  websocket_frame_deframer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // parser shadow state
  hdr_phase_e  phase_q = AWAIT_HDR0;
  logic [3:0]  frm_op = '0;
  logic        frm_fin = 1'b0;
  logic [7:0]  ext_hi = '0;
  logic [15:0] bytes_left = '0;
  logic [13:0] pong_acc = '0;
  logic        pong_digits = 1'b1;
  logic        halted = 1'b0;

  wsd_res_t    deframed_q[$];
  wsd_res_t    want;
  logic [7:0]  payload_q[$];

  int errors = 0;
  int cycles = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("websocket_frame_deframer_top regression: fail");
      $finish;
    end
  end

  // receiver: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task flag_mismatch(input string what, input int got, input int exp_v);
    errors++;
    $display("%0t: mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_v);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (deframed_q.size() == 0) begin
        flag_mismatch("word with nothing pending", out_tdata, 0);
      end else begin
        want = deframed_q.pop_front();
        if (out_tdata != want.payload_byte)
          flag_mismatch("payload_byte", out_tdata, want.payload_byte);
        if (out_tuser[0] != want.payload_valid)
          flag_mismatch("payload_valid", out_tuser[0], want.payload_valid);
        if (out_tuser[4:1] != want.frame_opcode)
          flag_mismatch("frame_opcode", out_tuser[4:1], want.frame_opcode);
        if (out_tuser[5] != want.final_fragment)
          flag_mismatch("final_fragment", out_tuser[5], want.final_fragment);
        if (out_tlast != want.frame_end)
          flag_mismatch("frame_end", out_tlast, want.frame_end);
        if (out_tuser[8:6] != want.status)
          flag_mismatch("status", out_tuser[8:6], want.status);
      end
    end
  end

  task queue_result(input logic [7:0] b, input logic valid, input logic last,
                    input logic [2:0] st);
    wsd_res_t r;
    r.payload_byte   = b;
    r.payload_valid  = valid;
    r.frame_opcode   = frm_op;
    r.final_fragment = frm_fin;
    r.frame_end      = last;
    r.status         = st;
    deframed_q.push_back(r);
  endtask

  function logic [2:0] end_of_frame(input logic [6:0] ping);
    logic [2:0] st;
    st = ST_OK;
    if (frm_op == OP_CLOSE)
      st = ST_CLOSE;
    else if (frm_op == OP_PONG && pong_digits && pong_acc != {7'd0, ping})
      st = ST_PONG_BAD;
    if (st != ST_OK)
      halted = 1'b1;
    phase_q = AWAIT_HDR0;
    return st;
  endfunction

  task header_fault(input logic [2:0] st);
    halted = 1'b1;
    phase_q = AWAIT_HDR0;
    queue_result(8'h00, 1'b0, 1'b0, st);
  endtask

  task open_payload(input logic [15:0] len, input logic [6:0] ping);
    bytes_left = len;
    pong_digits = (len == 16'd4);
    pong_acc = '0;
    if (len == 16'd0)
      queue_result(8'h00, 1'b0, 1'b1, end_of_frame(ping));
    else
      phase_q = IN_PAYLOAD;
  endtask

  task deframe_byte(input logic [7:0] b, input bit rs, input logic [6:0] ping);
    logic       last;
    logic [2:0] st;
    if (rs) begin
      phase_q = AWAIT_HDR0;
      frm_op = '0;
      frm_fin = 1'b0;
      ext_hi = '0;
      bytes_left = '0;
      pong_acc = '0;
      pong_digits = 1'b1;
      halted = 1'b0;
    end else if (!halted) begin
      case (phase_q)
        AWAIT_HDR0: begin
          frm_fin = b[7];
          frm_op = b[3:0];
          if ((b & HDR_RSV_MASK) != 8'h00)
            header_fault(ST_RSV);
          else
            phase_q = AWAIT_HDR1;
        end
        AWAIT_HDR1: begin
          if (b[7])
            header_fault(ST_MASKED);
          else if (b[6:0] == LEN_EXT64)
            header_fault(ST_LONG_LEN);
          else if (b[6:0] == LEN_EXT16)
            phase_q = AWAIT_EXT_HI;
          else
            open_payload({9'd0, b[6:0]}, ping);
        end
        AWAIT_EXT_HI: begin
          ext_hi = b;
          phase_q = AWAIT_EXT_LO;
        end
        AWAIT_EXT_LO: begin
          open_payload({ext_hi, b}, ping);
        end
        IN_PAYLOAD: begin
          if (pong_digits && b >= ASCII_ZERO && b <= ASCII_NINE)
            pong_acc = pong_acc * 14'd10 + (b - ASCII_ZERO);
          else
            pong_digits = 1'b0;
          bytes_left = bytes_left - 16'd1;
          last = (bytes_left == 16'd0);
          st = last ? end_of_frame(ping) : ST_OK;
          queue_result(b, 1'b1, last, st);
        end
        default: begin
          phase_q = AWAIT_HDR0;
        end
      endcase
    end
  endtask

  // ping < 0 picks a random expected ping for this word
  task automatic send_word(input logic [7:0] b, input bit rs, input int ping);
    logic [6:0] p;
    p = (ping < 0) ? 7'($urandom_range(100)) : 7'(ping);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, p, b};
    in_tuser <= rs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    deframe_byte(b, rs, p);
    words_sent++;
    @(negedge clk);
  endtask

  task resync_parser();
    send_word(8'($urandom), 1'b1, -1);
  endtask

  task automatic send_frame(input bit fin, input logic [3:0] op, input bit ext,
                            input int ping);
    int len;
    len = payload_q.size();
    send_word({fin, 3'b000, op}, 1'b0, ping);
    if (ext) begin
      send_word({1'b0, LEN_EXT16}, 1'b0, ping);
      send_word(8'(len >> 8), 1'b0, ping);
      send_word(8'(len), 1'b0, ping);
    end else begin
      send_word({1'b0, 7'(len)}, 1'b0, ping);
    end
    foreach (payload_q[i]) send_word(payload_q[i], 1'b0, ping);
    payload_q.delete();
  endtask

  task fill_random(input int n);
    repeat (n) payload_q.push_back(8'($urandom));
  endtask

  task fill_digits(input int v);
    payload_q.push_back(8'(v / 1000 % 10) + ASCII_ZERO);
    payload_q.push_back(8'(v / 100 % 10) + ASCII_ZERO);
    payload_q.push_back(8'(v / 10 % 10) + ASCII_ZERO);
    payload_q.push_back(8'(v % 10) + ASCII_ZERO);
  endtask

  task test_data_frames();
    payload_q.push_back(8'h00);
    payload_q.push_back(8'hFF);
    payload_q.push_back(8'h41);
    send_frame(1'b1, OP_TEXT, 1'b0, -1);
    send_frame(1'b0, OP_BINARY, 1'b0, -1);
    fill_random(3);
    send_frame(1'b1, OP_CONT, 1'b1, -1);
    send_frame(1'b1, OP_RSVD_CTRL, 1'b1, -1);
    fill_random(1);
    send_frame(1'b1, OP_PING, 1'b0, -1);
    fill_random(2);
    send_frame(1'b0, OP_RSVD_DATA, 1'b0, -1);
  endtask

  task test_header_errors();
    send_word({1'b1, 3'b100, OP_TEXT}, 1'b0, -1);
    send_word(8'hFF, 1'b0, -1);
    resync_parser();
    send_word({1'b0, 3'b010, OP_BINARY}, 1'b0, -1);
    resync_parser();
    send_word({1'b1, 3'b001, OP_CLOSE}, 1'b0, -1);
    resync_parser();
    send_word({1'b1, 3'b000, OP_TEXT}, 1'b0, -1);
    send_word({1'b1, 7'd5}, 1'b0, -1);
    resync_parser();
    send_word({1'b0, 3'b000, OP_BINARY}, 1'b0, -1);
    send_word({1'b0, LEN_EXT64}, 1'b0, -1);
    resync_parser();
    // resync in the middle of a payload
    send_word({1'b1, 3'b000, OP_TEXT}, 1'b0, -1);
    send_word({1'b0, 7'd5}, 1'b0, -1);
    fill_random(2);
    foreach (payload_q[i]) send_word(payload_q[i], 1'b0, -1);
    payload_q.delete();
    resync_parser();
    send_word({1'b1, 3'b000, OP_BINARY}, 1'b0, -1);
    send_word({1'b0, LEN_EXT16}, 1'b0, -1);
    send_word(8'hFF, 1'b0, -1);
    send_word(8'hFF, 1'b0, -1);
    send_word(8'h5A, 1'b0, -1);
    send_word(8'hA5, 1'b0, -1);
    resync_parser();
  endtask

  task test_control_frames();
    fill_random(2);
    send_frame(1'b1, OP_CLOSE, 1'b0, -1);
    send_word({1'b1, 3'b000, OP_TEXT}, 1'b0, -1);
    resync_parser();
    send_frame(1'b1, OP_CLOSE, 1'b0, -1);
    resync_parser();
    fill_digits(42);
    send_frame(1'b1, OP_PONG, 1'b0, 42);
    fill_digits(100);
    send_frame(1'b1, OP_PONG, 1'b1, 100);
    fill_digits(0);
    send_frame(1'b0, OP_PONG, 1'b0, 0);
    fill_digits(9999);
    send_frame(1'b1, OP_PONG, 1'b0, 99);
    resync_parser();
    // non-digit, short and long pong payloads skip the check
    fill_digits(64);
    payload_q[2] = "a";
    send_frame(1'b1, OP_PONG, 1'b0, 5);
    fill_digits(7);
    void'(payload_q.pop_back());
    send_frame(1'b1, OP_PONG, 1'b0, 0);
    fill_digits(12);
    payload_q.push_back(ASCII_NINE);
    send_frame(1'b1, OP_PONG, 1'b0, 1);
  endtask

  task test_backpressure();
    hold_requests++;
    fill_random(40);
    send_frame(1'b1, OP_BINARY, 1'b0, -1);
  endtask

  task automatic random_frame();
    int         pick;
    int         len;
    int         ping;
    bit         ext;
    bit         fin;
    logic [3:0] op;
    logic [7:0] hb;
    pick = $urandom_range(99);
    fin = 1'($urandom);
    op = 4'($urandom);
    if (pick < 65) begin
      if (op == OP_CLOSE || op == OP_PONG)
        op = OP_BINARY;
      ext = ($urandom_range(9) == 0);
      if (ext)
        len = $urandom_range(300);
      else if ($urandom_range(9) == 0)
        len = $urandom_range(125);
      else
        len = $urandom_range(24);
      fill_random(len);
      send_frame(fin, op, ext, -1);
    end else if (pick < 78) begin
      ping = $urandom_range(100);
      case ($urandom_range(3))
        0: fill_digits(ping);
        1: fill_digits($urandom_range(9999));
        2: begin
          fill_digits(ping);
          hb = $urandom_range(1) ? 8'($urandom_range(ASCII_ZERO - 1))
                                 : 8'($urandom_range(255, ASCII_NINE + 1));
          payload_q[$urandom_range(3)] = hb;
        end
        default: fill_random($urandom_range(8));
      endcase
      send_frame(fin, OP_PONG, $urandom_range(3) == 0, ping);
    end else if (pick < 83) begin
      fill_random($urandom_range(6));
      send_frame(fin, OP_CLOSE, $urandom_range(3) == 0, -1);
    end else if (pick < 92) begin
      case ($urandom_range(2))
        0: begin
          hb = 8'($urandom);
          hb[6:4] = 3'($urandom_range(7, 1));
          send_word(hb, 1'b0, -1);
        end
        1: begin
          send_word({fin, 3'b000, op}, 1'b0, -1);
          send_word({1'b1, 7'($urandom)}, 1'b0, -1);
        end
        default: begin
          send_word({fin, 3'b000, op}, 1'b0, -1);
          send_word({1'b0, LEN_EXT64}, 1'b0, -1);
        end
      endcase
    end else begin
      repeat ($urandom_range(6, 1)) send_word(8'($urandom), 1'b0, -1);
      resync_parser();
    end
    if (halted) begin
      repeat ($urandom_range(3)) send_word(8'($urandom), 1'b0, -1);
      resync_parser();
    end else if ($urandom_range(19) == 0) begin
      resync_parser();
    end
  endtask

  task automatic test_random_traffic(input int words, input int idle, input int stall);
    int start;
    send_idle_pct = idle;
    rx_stall_pct = stall;
    start = words_sent;
    while (words_sent - start < words) random_frame();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_data_frames();
    test_header_errors();
    test_control_frames();
    test_backpressure();
    test_random_traffic(500, 0, 0);
    test_random_traffic(500, 87, 0);
    test_random_traffic(500, 0, 87);
    test_random_traffic(500, 27, 27);
    in_tvalid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("websocket_frame_deframer_top regression: pass");
    else
      $display("websocket_frame_deframer_top regression: fail");
    $finish;
  end

endmodule

/* filelist.f */
rtl/wsd_pkg.sv
rtl/websocket_frame_deframer_top.sv
tb/sv/websocket_frame_deframer_top_tb.sv
